### design/ragr_pkg.sv
// ----------------------------------------------------------------------------
// ragr_pkg
// Shared types, constants and state codes for the rational ALU.
// ----------------------------------------------------------------------------
package ragr_pkg;

    localparam int OPERAND_BITS_DEF = 31;
    localparam int OPND_W = 31;
    localparam int RES_W  = 63;
    localparam int WIDE_W = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic              a_negative;
        logic [OPND_W-1:0] a_numerator;
        logic [OPND_W-1:0] a_denominator;
        logic              b_negative;
        logic [OPND_W-1:0] b_numerator;
        logic [OPND_W-1:0] b_denominator;
    } in_beat_t;

    typedef struct packed {
        logic             result_negative;
        logic [RES_W-1:0] result_numerator;
        logic [RES_W-1:0] result_denominator;
        logic             status;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMB,
        ST_GSHIFT,
        ST_GODD,
        ST_GSUB,
        ST_DIVSET,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic comb;
        logic gshift;
        logic godd;
        logic gsub;
        logic divset;
        logic divstep;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic err;
        logic zero;
        logic both_even;
        logic odd_done;
        logic equal;
        logic div_last;
    } dp_sts_t;

endpackage

### design/ragr_datapath.sv
// ----------------------------------------------------------------------------
// ragr_datapath
// Operand products, signed combine, binary GCD and restoring division.
// ----------------------------------------------------------------------------
module ragr_datapath #(
    parameter int OPERAND_BITS = ragr_pkg::OPERAND_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ragr_pkg::in_beat_t  in_beat,
    input  ragr_pkg::dp_cmd_t   cmd,
    output ragr_pkg::dp_sts_t   sts,
    output ragr_pkg::out_beat_t result
);
    import ragr_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic [OPERAND_BITS-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0]              op_reg;
    logic                    asg_reg, bsg_reg, neg_reg, err_reg;
    logic [WIDE_W-1:0]       p0_reg, p1_reg, p2_reg;
    logic [WIDE_W-1:0]       num_reg, den_reg, x_reg, y_reg, g_reg;
    logic [CNT_W-1:0]        shift_reg, cnt_reg;
    logic [WIDE_W-1:0]       rem_reg, quo_reg;
    logic                    which_reg;

    logic [WIDE_W-1:0] ta, tb, s_val;
    logic              a_err;

    assign a_err = (in_beat.a_denominator[OPERAND_BITS-1:0] == '0)
                || (in_beat.b_denominator[OPERAND_BITS-1:0] == '0)
                || ((in_beat.operation == OP_DIV)
                    && (in_beat.b_numerator[OPERAND_BITS-1:0] == '0));

    always_comb
    begin
        ta = asg_reg ? (~p0_reg + 64'd1) : p0_reg;
        tb = bsg_reg ? (~p1_reg + 64'd1) : p1_reg;
        s_val = (op_reg == OP_ADD) ? (ta + tb) : (ta - tb);
    end

    logic [WIDE_W-1:0] diff, rtry;
    logic [WIDE_W-1:0] divisor;
    logic [WIDE_W-1:0] dividend;
    assign diff    = (x_reg > y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);
    assign divisor = g_reg;
    assign dividend = which_reg ? den_reg : num_reg;
    assign rtry    = {rem_reg[WIDE_W-2:0], dividend[cnt_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            an_reg    <= '0;
            ad_reg    <= '0;
            bn_reg    <= '0;
            bd_reg    <= '0;
            op_reg    <= '0;
            asg_reg   <= 1'b0;
            bsg_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            err_reg   <= 1'b0;
            p0_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            num_reg   <= '0;
            den_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            g_reg     <= '0;
            shift_reg <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            which_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                an_reg  <= in_beat.a_numerator[OPERAND_BITS-1:0];
                ad_reg  <= in_beat.a_denominator[OPERAND_BITS-1:0];
                bn_reg  <= in_beat.b_numerator[OPERAND_BITS-1:0];
                bd_reg  <= in_beat.b_denominator[OPERAND_BITS-1:0];
                op_reg  <= in_beat.operation;
                asg_reg <= in_beat.a_negative;
                bsg_reg <= in_beat.b_negative;
                err_reg <= a_err;
            end
            if (cmd.mul)
            begin
                p0_reg <= WIDE_W'(an_reg) * WIDE_W'((op_reg == OP_MUL) ? bn_reg : bd_reg);
                p1_reg <= WIDE_W'(bn_reg) * WIDE_W'(ad_reg);
                p2_reg <= WIDE_W'(ad_reg) * WIDE_W'((op_reg == OP_DIV) ? bn_reg : bd_reg);
            end
            if (cmd.comb)
            begin
                den_reg   <= p2_reg;
                x_reg     <= p2_reg;
                shift_reg <= '0;
                if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    neg_reg <= s_val[WIDE_W-1];
                    num_reg <= s_val[WIDE_W-1] ? (~s_val + 64'd1) : s_val;
                    y_reg   <= s_val[WIDE_W-1] ? (~s_val + 64'd1) : s_val;
                end
                else
                begin
                    neg_reg <= asg_reg ^ bsg_reg;
                    num_reg <= p0_reg;
                    y_reg   <= p0_reg;
                end
            end
            if (cmd.gshift)
            begin
                x_reg     <= x_reg >> 1;
                y_reg     <= y_reg >> 1;
                shift_reg <= shift_reg + 1'b1;
            end
            // strip trailing zeros from either side, one bit a cycle
            if (cmd.godd)
            begin
                if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                if (!y_reg[0])
                    y_reg <= y_reg >> 1;
            end
            if (cmd.gsub)
            begin
                if (x_reg > y_reg)
                    x_reg <= diff;
                else
                    y_reg <= diff;
            end
            if (cmd.divset)
            begin
                g_reg     <= x_reg << shift_reg;
                rem_reg   <= '0;
                quo_reg   <= '0;
                cnt_reg   <= CNT_W'(WIDE_W-1);
                which_reg <= 1'b0;
            end
            if (cmd.divstep)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    which_reg <= 1'b1;
                    if (!which_reg)
                        num_reg <= {quo_reg[WIDE_W-2:0], rtry >= divisor};
                    else
                        den_reg <= {quo_reg[WIDE_W-2:0], rtry >= divisor};
                end
                else if (rtry >= divisor)
                begin
                    rem_reg <= rtry - divisor;
                    quo_reg <= {quo_reg[WIDE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rtry;
                    quo_reg <= {quo_reg[WIDE_W-2:0], 1'b0};
                end
            end
        end
    end

    assign sts.err       = err_reg;
    assign sts.zero      = (num_reg == '0);
    assign sts.both_even = !(x_reg[0] | y_reg[0]);
    assign sts.odd_done  = x_reg[0] & y_reg[0];
    assign sts.equal     = (x_reg == y_reg);
    assign sts.div_last  = (cnt_reg == '0) && which_reg;

    always_comb
    begin
        if (err_reg)
        begin
            result.result_negative    = 1'b0;
            result.result_numerator   = '0;
            result.result_denominator = RES_W'(1);
            result.status             = 1'b1;
        end
        else if (num_reg == '0)
        begin
            result.result_negative    = 1'b0;
            result.result_numerator   = '0;
            result.result_denominator = RES_W'(1);
            result.status             = 1'b0;
        end
        else
        begin
            result.result_negative    = neg_reg;
            result.result_numerator   = num_reg[RES_W-1:0];
            result.result_denominator = den_reg[RES_W-1:0];
            result.status             = 1'b0;
        end
    end

endmodule

### design/ragr_ctrl.sv
// ----------------------------------------------------------------------------
// ragr_ctrl
// Sequencer: multiply, combine, GCD loop, two divisions, output hold.
// ----------------------------------------------------------------------------
module ragr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ragr_pkg::dp_sts_t sts,
    output ragr_pkg::dp_cmd_t cmd
);
    import ragr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.err)
                    state_next = ST_DONE;
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_COMB;
                end
            end
            ST_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = ST_GSHIFT;
            end
            ST_GSHIFT:
            begin
                if (sts.zero)
                    state_next = ST_DONE;
                else if (sts.both_even)
                    cmd.gshift = 1'b1;
                else
                    state_next = ST_GODD;
            end
            ST_GODD:
            begin
                if (!sts.odd_done)
                    cmd.godd = 1'b1;
                else if (sts.equal)
                    state_next = ST_DIVSET;
                else
                    state_next = ST_GSUB;
            end
            ST_GSUB:
            begin
                cmd.gsub   = 1'b1;
                state_next = ST_GODD;
            end
            ST_DIVSET:
            begin
                cmd.divset = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.divstep = 1'b1;
                if (sts.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/rational_alu_with_gcd_reduce.sv
// ----------------------------------------------------------------------------
// rational_alu_with_gcd_reduce
// Rational add/sub/mul/div with reduction to lowest terms.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carrying in_beat (op and two fractions).
// Output channel: out_valid/out_stall carrying out_beat (sign, reduced
// numerator/denominator, status). One result beat per input beat.
// One item at a time: in_stall is low only while the unit is idle.
// From input accept to out_valid high: products and combine, then the
// binary GCD loop (shifting out common factors of two, stripping the
// remaining trailing zeros one bit at a time, subtract steps), then the
// division setup and the two 64-step restoring divisions. Errors go
// straight from the input check to the result; zero results skip the
// GCD loop and the divisions. After the result beat is accepted the
// sequencer returns to idle, where the next input is taken.
// The result beat holds in place while out_stall is high; the next input
// is taken only after it leaves.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// any item in flight.
// ----------------------------------------------------------------------------
module rational_alu_with_gcd_reduce #(
    parameter int OPERAND_BITS = ragr_pkg::OPERAND_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ragr_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_stall,
    output ragr_pkg::out_beat_t out_beat
);
    import ragr_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    ragr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ragr_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (in_beat),
        .cmd     (cmd),
        .sts     (sts),
        .result  (out_beat)
    );

endmodule

### design/ragr_checker.sv
// ----------------------------------------------------------------------------
// ragr_checker
// Port-level checks on the rational ALU, bound to the top level.
// ----------------------------------------------------------------------------
module ragr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ragr_pkg::out_beat_t out_beat
);
    import ragr_pkg::*;

    // held result beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_beat))
        else $error("result beat changed while stalled");

    // never accepting while a result is pending
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted with result pending");

    // an accepted item does not show a result next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid && in_stall)
        else $error("unexpected result timing");

    // error results are canonical
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.status |->
            !out_beat.result_negative && out_beat.result_numerator == '0
            && out_beat.result_denominator == RES_W'(1))
        else $error("error result not canonical");

endmodule

bind rational_alu_with_gcd_reduce ragr_checker u_ragr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
);
